### rtl/core/ppmd_pkg.sv
// Shared types and constants for the pulse-position decoder.
`timescale 1ns / 1ps
package ppmd_pkg;

  localparam int DUR_W         = 15;
  localparam int SHIFT_W       = 4;
  localparam int VALUE_W       = 30;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 15;
  localparam int START_POS     = 3;
  localparam int BITS_PER_SYMBOL_DEF = 2;
  localparam int SYMBOLS_DEF   = 15;

  localparam logic [DUR_W-1:0]   SYMBOL_TICKS_RST    = 15'd16;
  localparam logic [DUR_W-1:0]   TOLERANCE_TICKS_RST = 15'd4;
  localparam logic [DUR_W-1:0]   PAD_TICKS_RST       = 15'd0;
  localparam logic [SHIFT_W-1:0] SLOT_SHIFT_RST      = 4'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SYMBOL_TICKS    = 2'd0,
    REG_TOLERANCE_TICKS = 2'd1,
    REG_PAD_TICKS       = 2'd2,
    REG_SLOT_SHIFT      = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [DUR_W-1:0]   symbol_ticks;
    logic [DUR_W-1:0]   tolerance_ticks;
    logic [DUR_W-1:0]   pad_ticks;
    logic [SHIFT_W-1:0] slot_shift;
  } cfg_t;

  typedef struct packed {
    logic             message_start;
    logic [DUR_W-1:0] first_duration;
    logic [DUR_W-1:0] second_duration;
    logic             second_level;
  } rec_t;

  typedef struct packed {
    logic [VALUE_W-1:0] decoded_value;
    logic               upper_emitter;
    logic               message_ok;
  } res_t;

endpackage

### rtl/core/ppmd_if.sv
// Valid/ready channel interfaces for records, results and register writes.
`timescale 1ns / 1ps
interface ppmd_rec_if;
  import ppmd_pkg::*;
  logic             valid;
  logic             ready;
  logic             message_start;
  logic [DUR_W-1:0] first_duration;
  logic [DUR_W-1:0] second_duration;
  logic             second_level;

  modport source (output valid, message_start, first_duration, second_duration,
                  second_level, input ready);
  modport sink   (input valid, message_start, first_duration, second_duration,
                  second_level, output ready);
endinterface

interface ppmd_res_if;
  import ppmd_pkg::*;
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] decoded_value;
  logic               upper_emitter;
  logic               message_ok;

  modport source (output valid, decoded_value, upper_emitter, message_ok, input ready);
  modport sink   (input valid, decoded_value, upper_emitter, message_ok, output ready);
endinterface

interface ppmd_cfg_if;
  import ppmd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### rtl/core/ppmd_step.sv
// Per-record decode: slot arithmetic, window check, symbol packing, state update.
`timescale 1ns / 1ps
module ppmd_step #(
  parameter int BITS_PER_SYMBOL = ppmd_pkg::BITS_PER_SYMBOL_DEF,
  parameter int SYMBOLS         = ppmd_pkg::SYMBOLS_DEF,
  localparam int IDX_W = $clog2(SYMBOLS + 1),
  localparam int POS_W = (BITS_PER_SYMBOL < 2) ? 2 : BITS_PER_SYMBOL
) (
  input  ppmd_pkg::rec_t                rec,
  input  ppmd_pkg::cfg_t                cfg,
  input  logic [IDX_W-1:0]              idx,
  input  logic [POS_W-1:0]              pos,
  input  logic [ppmd_pkg::VALUE_W-1:0]  acc,
  input  logic                          disc,
  output logic [IDX_W-1:0]              idx_nxt,
  output logic [POS_W-1:0]              pos_nxt,
  output logic [ppmd_pkg::VALUE_W-1:0]  acc_nxt,
  output logic                          disc_nxt,
  output logic                          has_res,
  output ppmd_pkg::res_t                res
);
  import ppmd_pkg::*;

  localparam int SUM_W = DUR_W + 2;
  localparam int NP_W  = SUM_W + 1 + POS_W;
  localparam int SH_W  = IDX_W + 4;
  localparam logic [NP_W-1:0] LO = NP_W'(1) << BITS_PER_SYMBOL;
  localparam logic [NP_W-1:0] HI = NP_W'(2) << BITS_PER_SYMBOL;

  logic [IDX_W-1:0]         eff_idx;
  logic [POS_W-1:0]         eff_pos;
  logic [VALUE_W-1:0]       eff_acc;
  logic                     active;
  logic [SUM_W-1:0]         plus;
  logic [SUM_W-1:0]         diff;
  logic [NP_W-1:0]          new_pos;
  logic [BITS_PER_SYMBOL-1:0] sym;
  logic [SH_W-1:0]          shift_at;
  logic [DUR_W:0]           thresh;
  logic                     upper;

  always_comb begin
    active   = rec.message_start || !disc;
    eff_idx  = rec.message_start ? '0 : idx;
    eff_pos  = rec.message_start ? POS_W'(START_POS) : pos;
    eff_acc  = rec.message_start ? '0 : acc;
    plus     = SUM_W'(rec.first_duration) + SUM_W'(rec.second_duration)
             + SUM_W'(cfg.tolerance_ticks);
    diff     = plus - SUM_W'(cfg.pad_ticks);
    new_pos  = NP_W'(eff_pos) + NP_W'(diff >> cfg.slot_shift);
    sym      = new_pos[BITS_PER_SYMBOL-1:0];
    shift_at = SH_W'(eff_idx) * SH_W'(BITS_PER_SYMBOL);
    thresh   = (DUR_W+1)'(cfg.symbol_ticks) + (DUR_W+1)'(cfg.tolerance_ticks);
    upper    = (DUR_W+1)'(rec.first_duration) > thresh;
  end

  always_comb begin
    idx_nxt  = idx;
    pos_nxt  = pos;
    acc_nxt  = acc;
    disc_nxt = disc;
    has_res  = 1'b0;
    res      = '0;
    if (active) begin
      idx_nxt  = eff_idx;
      pos_nxt  = eff_pos;
      acc_nxt  = eff_acc;
      disc_nxt = 1'b0;
      if (eff_idx == '0 && rec.second_level) begin
        has_res  = 1'b1;
        disc_nxt = 1'b1;
      end else if (eff_idx >= IDX_W'(SYMBOLS)) begin
        has_res  = 1'b1;
        disc_nxt = 1'b1;
        if (rec.second_duration == '0) begin
          res.decoded_value = eff_acc;
          res.upper_emitter = upper;
          res.message_ok    = 1'b1;
        end
      end else if (rec.second_duration == '0 || plus < SUM_W'(cfg.pad_ticks) ||
                   new_pos < LO || new_pos >= HI) begin
        has_res  = 1'b1;
        disc_nxt = 1'b1;
      end else begin
        pos_nxt = POS_W'(sym);
        acc_nxt = eff_acc | (VALUE_W'(sym) << shift_at);
        idx_nxt = eff_idx + 1'b1;
      end
    end
  end

endmodule

### rtl/core/ppm_pulse_decoder.sv
// Top level of the pulse-position decoder: register file, record stage, result register.
//
// Channels: in_rec takes pulse records, out_res gives one result per message,
// cfg_wr writes the four timing registers (index 0..3); cfg_wr.ready is always high.
// A transfer on in_rec loads the record stage. Once the result register is free, the
// record is decoded against the message state and, when it ends a message, the result
// register is loaded and offered on out_res.
// One record per cycle is sustained while out_res does not stall; the decode is
// add, shift and window compare logic between the record stage and result register.
// A message is SYMBOLS+1 records starting with message_start; a failed or
// finished message yields exactly one result, and records up to the next
// message_start are dropped.
// Reset clears both stages, loads the register defaults and waits for a start.
// When out_res stalls, the held result waits and the record stage holds one more
// record; in_rec.ready drops only when both are full and out_res.ready is low.
`timescale 1ns / 1ps
module ppm_pulse_decoder #(
  parameter int BITS_PER_SYMBOL = ppmd_pkg::BITS_PER_SYMBOL_DEF,
  parameter int SYMBOLS         = ppmd_pkg::SYMBOLS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  ppmd_rec_if.sink  in_rec,
  ppmd_res_if.source out_res,
  ppmd_cfg_if.sink  cfg_wr
);
  import ppmd_pkg::*;

  localparam int IDX_W = $clog2(SYMBOLS + 1);
  localparam int POS_W = (BITS_PER_SYMBOL < 2) ? 2 : BITS_PER_SYMBOL;

  cfg_t               cfg_r;
  rec_t               rec_r;
  logic               rec_valid_r;
  res_t               res_r;
  logic               res_valid_r;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [VALUE_W-1:0] acc_r, acc_nxt;
  logic               disc_r, disc_nxt;
  logic               has_res;
  res_t               res_nxt;
  logic               out_free;
  logic               step_fire;
  logic               in_xfer;

  assign out_free  = !res_valid_r || out_res.ready;
  assign step_fire = rec_valid_r && out_free;
  assign in_rec.ready = !rec_valid_r || out_free;
  assign in_xfer   = in_rec.valid && in_rec.ready;
  assign cfg_wr.ready = 1'b1;

  assign out_res.valid         = res_valid_r;
  assign out_res.decoded_value = res_r.decoded_value;
  assign out_res.upper_emitter = res_r.upper_emitter;
  assign out_res.message_ok    = res_r.message_ok;

  ppmd_step #(
    .BITS_PER_SYMBOL (BITS_PER_SYMBOL),
    .SYMBOLS         (SYMBOLS)
  ) u_step (
    .rec      (rec_r),
    .cfg      (cfg_r),
    .idx      (idx_r),
    .pos      (pos_r),
    .acc      (acc_r),
    .disc     (disc_r),
    .idx_nxt  (idx_nxt),
    .pos_nxt  (pos_nxt),
    .acc_nxt  (acc_nxt),
    .disc_nxt (disc_nxt),
    .has_res  (has_res),
    .res      (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.symbol_ticks    <= SYMBOL_TICKS_RST;
      cfg_r.tolerance_ticks <= TOLERANCE_TICKS_RST;
      cfg_r.pad_ticks       <= PAD_TICKS_RST;
      cfg_r.slot_shift      <= SLOT_SHIFT_RST;
    end else if (cfg_wr.valid) begin
      unique case (cfg_reg_t'(cfg_wr.index))
        REG_SYMBOL_TICKS:    cfg_r.symbol_ticks    <= cfg_wr.data;
        REG_TOLERANCE_TICKS: cfg_r.tolerance_ticks <= cfg_wr.data;
        REG_PAD_TICKS:       cfg_r.pad_ticks       <= cfg_wr.data;
        REG_SLOT_SHIFT:      cfg_r.slot_shift      <= cfg_wr.data[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_valid_r <= 1'b0;
      res_valid_r <= 1'b0;
      idx_r       <= '0;
      pos_r       <= POS_W'(START_POS);
      acc_r       <= '0;
      disc_r      <= 1'b1;
    end else begin
      if (in_xfer) begin
        rec_valid_r <= 1'b1;
      end else if (step_fire) begin
        rec_valid_r <= 1'b0;
      end
      if (step_fire) begin
        res_valid_r <= has_res;
        idx_r       <= idx_nxt;
        pos_r       <= pos_nxt;
        acc_r       <= acc_nxt;
        disc_r      <= disc_nxt;
      end else if (out_res.ready) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      rec_r.message_start   <= in_rec.message_start;
      rec_r.first_duration  <= in_rec.first_duration;
      rec_r.second_duration <= in_rec.second_duration;
      rec_r.second_level    <= in_rec.second_level;
    end
    if (step_fire && has_res) begin
      res_r <= res_nxt;
    end
  end

endmodule

### rtl/core/ppmd_checker.sv
// Port-level assertions for the pulse-position decoder, bound to the top level.
`timescale 1ns / 1ps
module ppmd_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [ppmd_pkg::VALUE_W-1:0] decoded_value,
  input logic                         upper_emitter,
  input logic                         message_ok
);
  import ppmd_pkg::*;

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_fail_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !message_ok) |-> (decoded_value == '0 && !upper_emitter))
    else $error("failed message carries nonzero fields");

  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

  a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      ($stable(decoded_value) && $stable(upper_emitter) && $stable(message_ok)))
    else $error("result changed while stalled");

endmodule

bind ppm_pulse_decoder ppmd_checker u_ppmd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_res.valid),
  .out_ready     (out_res.ready),
  .decoded_value (out_res.decoded_value),
  .upper_emitter (out_res.upper_emitter),
  .message_ok    (out_res.message_ok)
);

### test/ppm_pulse_decoder_tb.sv
// Self-checking testbench for ppm_pulse_decoder: random pulse messages checked against a predictor.
`timescale 1ns / 1ps
module ppm_pulse_decoder_tb;
  import ppmd_pkg::*;

  localparam int DUR_MAX     = (1 << DUR_W) - 1;
  localparam int SYM_WINDOW  = 1 << BITS_PER_SYMBOL_DEF;
  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_TAIL  = 6;

  typedef enum int {
    FLT_LEVEL, FLT_EARLY_END, FLT_WILD, FLT_NEG_SUM, FLT_LONG_FINAL, FLT_RESTART, FLT_TRUNCATE
  } fault_t;

  class msg_scoreboard;
    cfg_t regs;
    int rec_idx;
    int slot_pos;
    logic [VALUE_W-1:0] packed_syms;
    bit skipping;
    res_t expected_msgs[$];
    int errors;
    int taken;

    function new();
      regs.symbol_ticks    = SYMBOL_TICKS_RST;
      regs.tolerance_ticks = TOLERANCE_TICKS_RST;
      regs.pad_ticks       = PAD_TICKS_RST;
      regs.slot_shift      = SLOT_SHIFT_RST;
      rec_idx = 0;
      slot_pos = START_POS;
      packed_syms = '0;
      skipping = 1'b1;
      errors = 0;
      taken = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_SYMBOL_TICKS:    regs.symbol_ticks = data;
        REG_TOLERANCE_TICKS: regs.tolerance_ticks = data;
        REG_PAD_TICKS:       regs.pad_ticks = data;
        REG_SLOT_SHIFT:      regs.slot_shift = data[SHIFT_W-1:0];
        default: ;
      endcase
    endfunction

    // returns 1 when the record ends a message, with the message result in res
    function bit decode_record(rec_t r, output res_t res);
      int sum;
      int pad;
      int at;
      logic [VALUE_W-1:0] sym_bits;
      res = '0;
      pad = int'(regs.pad_ticks);
      if (r.message_start) begin
        rec_idx = 0;
        slot_pos = START_POS;
        packed_syms = '0;
        skipping = 1'b0;
      end else if (skipping) begin
        return 1'b0;
      end
      taken++;
      if (rec_idx == 0 && r.second_level) begin
        skipping = 1'b1;
        return 1'b1;
      end
      if (rec_idx >= SYMBOLS_DEF) begin
        skipping = 1'b1;
        if (r.second_duration != 0) return 1'b1;
        res.decoded_value = packed_syms;
        res.upper_emitter =
          int'(r.first_duration) > int'(regs.symbol_ticks) + int'(regs.tolerance_ticks);
        res.message_ok = 1'b1;
        return 1'b1;
      end
      if (r.second_duration == 0) begin
        skipping = 1'b1;
        return 1'b1;
      end
      sum = int'(r.first_duration) + int'(r.second_duration) + int'(regs.tolerance_ticks);
      if (sum < pad) begin
        skipping = 1'b1;
        return 1'b1;
      end
      slot_pos += (sum - pad) >> regs.slot_shift;
      if (slot_pos < SYM_WINDOW || slot_pos >= 2 * SYM_WINDOW) begin
        skipping = 1'b1;
        return 1'b1;
      end
      slot_pos -= SYM_WINDOW;
      at = rec_idx * BITS_PER_SYMBOL_DEF;
      sym_bits = VALUE_W'(slot_pos);
      if (at < VALUE_W) packed_syms = packed_syms | (sym_bits << at);
      rec_idx++;
      return 1'b0;
    endfunction

    function void note_record(rec_t r);
      res_t res;
      if (decode_record(r, res)) expected_msgs.push_back(res);
    endfunction

    function void report(string what, longint unsigned want, longint unsigned got);
      errors++;
      $display("%0t: %s expected %h actual %h", $time, what, want, got);
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (expected_msgs.size() == 0) begin
        report("unexpected transfer, result", 0, got);
        return;
      end
      want = expected_msgs.pop_front();
      if (got.decoded_value !== want.decoded_value)
        report("decoded_value", want.decoded_value, got.decoded_value);
      if (got.upper_emitter !== want.upper_emitter)
        report("upper_emitter", want.upper_emitter, got.upper_emitter);
      if (got.message_ok !== want.message_ok)
        report("message_ok", want.message_ok, got.message_ok);
    endfunction

    function int pending();
      return expected_msgs.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit idle_on = 1'b1;
  int hold_cycles = 0;
  int unsigned cycle_count = 0;
  msg_scoreboard sb = new();

  ppmd_rec_if in_rec();
  ppmd_res_if out_res();
  ppmd_cfg_if cfg_wr();

  ppm_pulse_decoder u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_rec (in_rec),
    .out_res(out_res),
    .cfg_wr (cfg_wr)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ppm_pulse_decoder: mismatch");
      $finish;
    end
  end

  // transfer monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_wr.valid && cfg_wr.ready)
        sb.set_reg(cfg_reg_t'(cfg_wr.index), cfg_wr.data);
      if (in_rec.valid && in_rec.ready)
        sb.note_record('{in_rec.message_start, in_rec.first_duration,
                         in_rec.second_duration, in_rec.second_level});
      if (out_res.valid && out_res.ready)
        sb.check_result('{out_res.decoded_value, out_res.upper_emitter, out_res.message_ok});
    end
  end

  // result side back-pressure
  initial begin
    int n;
    out_res.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        n = hold_cycles;
        hold_cycles = 0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 6);
      end else begin
        n = 0;
      end
      if (n > 0) begin
        out_res.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_res.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  function automatic rec_t make_rec(bit start, int d0, int d1, bit level);
    rec_t r;
    r.message_start = start;
    r.first_duration = DUR_W'(d0);
    r.second_duration = DUR_W'(d1);
    r.second_level = level;
    return r;
  endfunction

  task automatic send_record(rec_t r);
    in_rec.valid <= 1'b1;
    in_rec.message_start <= r.message_start;
    in_rec.first_duration <= r.first_duration;
    in_rec.second_duration <= r.second_duration;
    in_rec.second_level <= r.second_level;
    do @(posedge clk); while (!in_rec.ready);
  endtask

  task automatic pause_sender();
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_rec.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic wait_results_done();
    in_rec.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    cfg_wr.valid <= 1'b1;
    cfg_wr.index <= idx;
    cfg_wr.data <= data;
    do @(posedge clk); while (!cfg_wr.ready);
  endtask

  task automatic configure(int sym, int tol, int pad, int shift);
    wait_results_done();
    write_reg(REG_SYMBOL_TICKS, CFG_DATA_W'(sym));
    write_reg(REG_TOLERANCE_TICKS, CFG_DATA_W'(tol));
    write_reg(REG_PAD_TICKS, CFG_DATA_W'(pad));
    write_reg(REG_SLOT_SHIFT, CFG_DATA_W'(shift));
    cfg_wr.valid <= 1'b0;
    @(posedge clk);
  endtask

  // one message built for the current timing, optionally broken at one record
  task automatic send_message(bit clean);
    rec_t r;
    int prev, sym, slots, total, lo_d1, hi_d1, thr, shift, fault_at;
    fault_t fault;
    prev = START_POS;
    shift = sb.regs.slot_shift;
    fault_at = clean ? -1 : $urandom_range(0, SYMBOLS_DEF);
    fault = fault_t'($urandom_range(FLT_LEVEL, FLT_TRUNCATE));
    for (int i = 0; i <= SYMBOLS_DEF; i++) begin
      r.message_start = (i == 0);
      r.second_level = (i == 0) ? 1'b0 : 1'($urandom_range(0, 1));
      if (i < SYMBOLS_DEF) begin
        sym = $urandom_range(0, SYM_WINDOW - 1);
        slots = SYM_WINDOW + sym - prev;
        prev = sym;
        total = (slots << shift) + int'(sb.regs.pad_ticks) - int'(sb.regs.tolerance_ticks)
                + $urandom_range(0, (1 << shift) - 1);
        if (total < 1) total = 1;
        if (total > 2 * DUR_MAX) total = 2 * DUR_MAX;
        lo_d1 = (total - DUR_MAX > 1) ? total - DUR_MAX : 1;
        hi_d1 = (total < DUR_MAX) ? total : DUR_MAX;
        r.second_duration = DUR_W'($urandom_range(lo_d1, hi_d1));
        r.first_duration = DUR_W'(total - int'(r.second_duration));
      end else begin
        thr = int'(sb.regs.symbol_ticks) + int'(sb.regs.tolerance_ticks) - 1
              + $urandom_range(0, 2);
        if (thr > DUR_MAX) thr = DUR_MAX;
        r.second_duration = '0;
        r.first_duration = $urandom_range(0, 1) ? DUR_W'($urandom_range(0, DUR_MAX))
                                                : DUR_W'(thr);
      end
      if (i == fault_at) begin
        case (fault)
          FLT_LEVEL:      r.second_level = 1'b1;
          FLT_EARLY_END:  r.second_duration = '0;
          FLT_WILD: begin
            r.first_duration = DUR_W'($urandom_range(0, DUR_MAX));
            r.second_duration = DUR_W'($urandom_range(0, DUR_MAX));
          end
          FLT_NEG_SUM: begin
            r.first_duration = '0;
            r.second_duration = DUR_W'(1);
          end
          FLT_LONG_FINAL: r.second_duration = DUR_W'($urandom_range(1, DUR_MAX));
          FLT_RESTART:    r.message_start = 1'b1;
          default: ;
        endcase
      end
      send_record(r);
      pause_sender();
      if (i == fault_at && fault == FLT_TRUNCATE) break;
    end
  endtask

  task automatic run_phase(int amount);
    int goal, pick;
    goal = sb.taken + amount;
    while (sb.taken < goal) begin
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
        repeat ($urandom_range(1, 3)) begin
          send_record(make_rec($urandom_range(0, 3) == 0, $urandom_range(0, DUR_MAX),
                               ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, DUR_MAX),
                               $urandom_range(0, 1)));
          pause_sender();
        end
      end else begin
        send_message(pick >= 5);
      end
    end
  endtask

  initial begin
    in_rec.valid <= 1'b0;
    in_rec.message_start <= 1'b0;
    in_rec.first_duration <= '0;
    in_rec.second_duration <= '0;
    in_rec.second_level <= 1'b0;
    cfg_wr.valid <= 1'b0;
    cfg_wr.index <= REG_SYMBOL_TICKS;
    cfg_wr.data <= '0;
    rst_n <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    configure(16, 4, 8, 4);
    send_record(make_rec(0, DUR_MAX, DUR_MAX, 1));   // dropped, no start seen yet
    send_record(make_rec(1, 0, 5, 1));               // first record with high level
    send_record(make_rec(0, 1, 1, 0));               // dropped after the failure
    pause_sender();
    send_record(make_rec(1, DUR_MAX, 0, 0));         // early end
    send_record(make_rec(1, DUR_MAX, DUR_MAX, 0));   // position far above window
    send_record(make_rec(1, 0, 1, 0));               // sum below padding
    send_record(make_rec(1, 3, 3, 0));               // position below window
    send_record(make_rec(1, 20, 20, 0));             // good symbol, then abandoned
    pause_sender();
    send_message(1'b1);

    configure(1, 0, 0, 0);
    run_phase(80);

    configure(DUR_MAX, DUR_MAX, DUR_MAX, DUR_MAX);
    run_phase(40);

    configure(100, 7, 300, 6);
    hold_cycles = 80;
    run_phase(100);

    configure($urandom_range(1, DUR_MAX), $urandom_range(0, 300), $urandom_range(0, 600),
              $urandom_range(0, 9));
    run_phase(50);
    wait_results_done();
    run_phase(50);

    idle_on = 1'b0;
    configure(40, 3, 12, 3);
    run_phase(80);

    wait_results_done();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ppm_pulse_decoder: match");
    end else begin
      $display("ppm_pulse_decoder: mismatch");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/ppmd_pkg.sv
rtl/core/ppmd_if.sv
rtl/core/ppmd_step.sv
rtl/core/ppm_pulse_decoder.sv
rtl/core/ppmd_checker.sv
test/ppm_pulse_decoder_tb.sv
